// File: src/dts_pkg.sv
// ----------------------------------------------------------------------------
// Date/time setting controller package
// Types, button and mode codes, and the calendar helpers shared by the block.
// ----------------------------------------------------------------------------
package dts_pkg;

  // Button codes.
  localparam logic [2:0] FUNC_PLAY  = 3'd0;
  localparam logic [2:0] FUNC_PAUSE = 3'd1;
  localparam logic [2:0] FUNC_STOP  = 3'd2;
  localparam logic [2:0] FUNC_UP    = 3'd3;
  localparam logic [2:0] FUNC_DOWN  = 3'd4;

  // Mode codes.
  localparam logic [2:0] MODE_VIEW   = 3'd0;
  localparam logic [2:0] MODE_YEAR   = 3'd1;
  localparam logic [2:0] MODE_MONTH  = 3'd2;
  localparam logic [2:0] MODE_DAY    = 3'd3;
  localparam logic [2:0] MODE_HOUR   = 3'd4;
  localparam logic [2:0] MODE_MINUTE = 3'd5;

  localparam logic [13:0] MAX_YEAR   = 14'd9999;
  localparam logic [3:0]  MAX_MONTH  = 4'd12;
  localparam logic [4:0]  MAX_HOUR   = 5'd23;
  localparam logic [5:0]  MAX_MINUTE = 6'd59;

  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_APR = 4'd4;
  localparam logic [3:0] MONTH_JUN = 4'd6;
  localparam logic [3:0] MONTH_SEP = 4'd9;
  localparam logic [3:0] MONTH_NOV = 4'd11;

  // Floor(y / 100) as (y * 5243) >> 19, exact for every 14-bit y.
  localparam logic [12:0] DIV100_MUL = 13'd5243;

  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  target_id;
    logic [13:0] now_year;
    logic [3:0]  now_month;
    logic [4:0]  now_day;
    logic [4:0]  now_hour;
    logic [5:0]  now_minute;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
  } state_t;

  typedef struct packed {
    state_t st;
    logic   commit;
    logic   cancelled;
  } out_word_t;

  localparam state_t STATE_RESET = '{mode: MODE_VIEW, year: 14'd0, month: 4'd1,
                                     day: 5'd1, hour: 5'd0, minute: 6'd0};

  // Gregorian leap year test without a divider.
  function automatic logic is_leap(input logic [13:0] y);
    logic [26:0] prod;
    logic [7:0]  q;
    logic [13:0] hundreds;
    logic        cent;
    prod     = 27'(y) * 27'(DIV100_MUL);
    q        = prod[26:19];
    hundreds = {q, 6'b0} + {1'b0, q, 5'b0} + {4'b0, q, 2'b0};
    cent     = (y == hundreds);
    return ((y[1:0] == 2'b00) && !cent) || (cent && (q[1:0] == 2'b00));
  endfunction

  function automatic logic [4:0] month_len(input logic [13:0] y, input logic [3:0] m);
    logic [4:0] len;
    len = 5'd31;
    case (m)
      MONTH_FEB: len = is_leap(y) ? 5'd29 : 5'd28;
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// File: src/dts_in_if.sv
// ----------------------------------------------------------------------------
// Button press channel
// Valid/ready channel carrying one button press word.
// ----------------------------------------------------------------------------
interface dts_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [7:0]  target_id;
  logic [13:0] now_year;
  logic [3:0]  now_month;
  logic [4:0]  now_day;
  logic [4:0]  now_hour;
  logic [5:0]  now_minute;

  modport source (output valid, func, target_id, now_year, now_month, now_day,
                  now_hour, now_minute, input ready);
  modport sink (input valid, func, target_id, now_year, now_month, now_day,
                now_hour, now_minute, output ready);
endinterface

// File: src/dts_out_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying the controller state after each press.
// ----------------------------------------------------------------------------
interface dts_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [13:0] edit_year;
  logic [3:0]  edit_month;
  logic [4:0]  edit_day;
  logic [4:0]  edit_hour;
  logic [5:0]  edit_minute;
  logic        commit;
  logic        cancelled;

  modport source (output valid, mode, edit_year, edit_month, edit_day, edit_hour,
                  edit_minute, commit, cancelled, input ready);
  modport sink (input valid, mode, edit_year, edit_month, edit_day, edit_hour,
                edit_minute, commit, cancelled, output ready);
endinterface

// File: src/date_time_setting_controller.sv
// ----------------------------------------------------------------------------
// Date and time setting controller
// Button-driven edit of year, month, day, hour and minute.
//
// Usage:
//   press  : one button word per press (button code, target id and the
//            displayed date and time used when edit mode is entered).
//   result : one word per accepted press with the mode, the edit fields and
//            the commit and cancel flags.
//   cfg_we/cfg_data : write the controller id; write only while idle.
// Every accepted press gives exactly one result word, held first in the input
// register and then in the result register. A new press is accepted every
// cycle while the receiver takes results; the state update is a single pass
// of logic between the two registers; the month-length lookup bounds it.
// Reset clears both registers, puts the block in view mode with the edit
// fields at year 0, January 1st, 00:00, and sets the id to 0.
// If the receiver stalls, the result word holds and the input register keeps
// one more press; after that press.ready drops until the result is taken.
// ----------------------------------------------------------------------------
module date_time_setting_controller (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data,
  dts_in_if.sink     press,
  dts_out_if.source  result
);

  logic               held_valid;
  dts_pkg::in_word_t  held_word;
  logic               advance;
  logic [7:0]         own_id;
  dts_pkg::state_t    state;
  dts_pkg::state_t    state_next;
  logic               commit_next;
  logic               cancelled_next;
  logic               out_valid;
  dts_pkg::out_word_t out_word;

  assign advance = held_valid && (!out_valid || result.ready);

  dts_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .press      (press),
    .advance    (advance),
    .held_valid (held_valid),
    .held_word  (held_word)
  );

  dts_core u_core (
    .word       (held_word),
    .state      (state),
    .own_id     (own_id),
    .state_next (state_next),
    .commit     (commit_next),
    .cancelled  (cancelled_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      own_id <= 8'd0;
    end else if (cfg_we) begin
      own_id <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dts_pkg::STATE_RESET;
      out_valid <= 1'b0;
    end else if (advance) begin
      state     <= state_next;
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word.st        <= state_next;
      out_word.commit    <= commit_next;
      out_word.cancelled <= cancelled_next;
    end
  end

  assign result.valid       = out_valid;
  assign result.mode        = out_word.st.mode;
  assign result.edit_year   = out_word.st.year;
  assign result.edit_month  = out_word.st.month;
  assign result.edit_day    = out_word.st.day;
  assign result.edit_hour   = out_word.st.hour;
  assign result.edit_minute = out_word.st.minute;
  assign result.commit      = out_word.commit;
  assign result.cancelled   = out_word.cancelled;

endmodule

// File: src/dts_in_stage.sv
// ----------------------------------------------------------------------------
// Input register
// Captures one press word; refills in the same cycle the held word moves on.
// ----------------------------------------------------------------------------
module dts_in_stage (
  input  logic             clk,
  input  logic             rst,
  dts_in_if.sink           press,
  input  logic             advance,
  output logic             held_valid,
  output dts_pkg::in_word_t held_word
);

  assign press.ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (press.ready) begin
      held_valid <= press.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (press.valid && press.ready) begin
      held_word.func       <= press.func;
      held_word.target_id  <= press.target_id;
      held_word.now_year   <= press.now_year;
      held_word.now_month  <= press.now_month;
      held_word.now_day    <= press.now_day;
      held_word.now_hour   <= press.now_hour;
      held_word.now_minute <= press.now_minute;
    end
  end

endmodule

// File: src/dts_core.sv
// ----------------------------------------------------------------------------
// Press decoder and field update
// Computes the next mode and edit fields for one press.
// ----------------------------------------------------------------------------
module dts_core (
  input  dts_pkg::in_word_t word,
  input  dts_pkg::state_t   state,
  input  logic [7:0]        own_id,
  output dts_pkg::state_t   state_next,
  output logic              commit,
  output logic              cancelled
);

  logic        hit;
  logic [2:0]  mode_mid;
  logic [13:0] year_mid;
  logic [3:0]  month_mid;
  logic [4:0]  day_mid;
  logic [4:0]  hour_mid;
  logic [5:0]  minute_mid;
  logic        day_up;
  logic        day_dn;
  logic [4:0]  len;
  logic        up;

  assign hit = (word.target_id == own_id) &&
               (word.func inside {[dts_pkg::FUNC_PLAY:dts_pkg::FUNC_DOWN]});
  assign up  = (word.func == dts_pkg::FUNC_UP);

  always_comb begin
    mode_mid   = state.mode;
    year_mid   = state.year;
    month_mid  = state.month;
    day_mid    = state.day;
    hour_mid   = state.hour;
    minute_mid = state.minute;
    day_up     = 1'b0;
    day_dn     = 1'b0;
    commit     = 1'b0;
    cancelled  = 1'b0;
    if (hit) begin
      if (state.mode == dts_pkg::MODE_VIEW) begin
        if (word.func == dts_pkg::FUNC_STOP) begin
          // Load the displayed time, saturating anything out of range.
          year_mid = (word.now_year > dts_pkg::MAX_YEAR) ? dts_pkg::MAX_YEAR
                                                         : word.now_year;
          if (word.now_month == 4'd0) begin
            month_mid = 4'd1;
          end else if (word.now_month > dts_pkg::MAX_MONTH) begin
            month_mid = dts_pkg::MAX_MONTH;
          end else begin
            month_mid = word.now_month;
          end
          day_mid = word.now_day;
          hour_mid = (word.now_hour > dts_pkg::MAX_HOUR) ? dts_pkg::MAX_HOUR
                                                         : word.now_hour;
          minute_mid = (word.now_minute > dts_pkg::MAX_MINUTE)
                       ? dts_pkg::MAX_MINUTE : word.now_minute;
          mode_mid = dts_pkg::MODE_YEAR;
        end
      end else begin
        case (word.func)
          dts_pkg::FUNC_PLAY: begin
            if (state.mode >= dts_pkg::MODE_MINUTE) begin
              mode_mid = dts_pkg::MODE_VIEW;
              commit = 1'b1;
            end else begin
              mode_mid = state.mode + 3'd1;
            end
          end
          dts_pkg::FUNC_PAUSE: begin
            if (state.mode > dts_pkg::MODE_YEAR) begin
              mode_mid = state.mode - 3'd1;
            end
          end
          dts_pkg::FUNC_STOP: begin
            mode_mid = dts_pkg::MODE_VIEW;
            cancelled = 1'b1;
          end
          dts_pkg::FUNC_UP, dts_pkg::FUNC_DOWN: begin
            case (state.mode)
              dts_pkg::MODE_YEAR: begin
                if (up) begin
                  year_mid = (state.year >= dts_pkg::MAX_YEAR) ? 14'd0
                                                               : state.year + 14'd1;
                end else begin
                  year_mid = (state.year == 14'd0) ? dts_pkg::MAX_YEAR
                                                   : state.year - 14'd1;
                end
              end
              dts_pkg::MODE_MONTH: begin
                if (up) begin
                  month_mid = (state.month >= dts_pkg::MAX_MONTH) ? 4'd1
                                                                  : state.month + 4'd1;
                end else begin
                  month_mid = (state.month <= 4'd1) ? dts_pkg::MAX_MONTH
                                                    : state.month - 4'd1;
                end
              end
              dts_pkg::MODE_DAY: begin
                day_up = up;
                day_dn = !up;
              end
              dts_pkg::MODE_HOUR: begin
                if (up) begin
                  hour_mid = (state.hour >= dts_pkg::MAX_HOUR) ? 5'd0
                                                               : state.hour + 5'd1;
                end else begin
                  hour_mid = (state.hour == 5'd0) ? dts_pkg::MAX_HOUR
                                                  : state.hour - 5'd1;
                end
              end
              dts_pkg::MODE_MINUTE: begin
                if (up) begin
                  minute_mid = (state.minute >= dts_pkg::MAX_MINUTE) ? 6'd0
                               : state.minute + 6'd1;
                end else begin
                  minute_mid = (state.minute == 6'd0) ? dts_pkg::MAX_MINUTE
                               : state.minute - 6'd1;
                end
              end
              default: begin
              end
            endcase
          end
          default: begin
          end
        endcase
      end
    end
  end

  // In day edit the year and month are unchanged, so one month length serves
  // both the day wrap and the clamp after a year or month change.
  assign len = dts_pkg::month_len(year_mid, month_mid);

  always_comb begin
    state_next.mode   = mode_mid;
    state_next.year   = year_mid;
    state_next.month  = month_mid;
    state_next.hour   = hour_mid;
    state_next.minute = minute_mid;
    if (day_up) begin
      state_next.day = (day_mid >= len) ? 5'd1 : day_mid + 5'd1;
    end else if (day_dn) begin
      state_next.day = (day_mid <= 5'd1) ? len : day_mid - 5'd1;
    end else if (day_mid > len) begin
      state_next.day = len;
    end else if (day_mid == 5'd0) begin
      state_next.day = 5'd1;
    end else begin
      state_next.day = day_mid;
    end
  end

endmodule

// File: src/dts_checker.sv
// ----------------------------------------------------------------------------
// Result channel checker
// Port-level properties of the result words, bound to the top level.
// ----------------------------------------------------------------------------
module dts_checker (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic [2:0]  res_mode,
  input logic [3:0]  res_month,
  input logic [4:0]  res_day,
  input logic        res_commit,
  input logic        res_cancelled
);

  // Nothing is presented right after reset.
  a_reset_idle: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  // A commit or a cancel always lands back in view mode.
  a_exit_view: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_commit || res_cancelled) |-> res_mode == dts_pkg::MODE_VIEW)
    else $error("commit or cancel outside view mode");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res_commit && res_cancelled))
    else $error("commit and cancel together");

  // Month stays in 1..12 and day is non-zero in every valid result word.
  a_date_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_month >= 4'd1 && res_month <= 4'd12 && res_day != 5'd0)
    else $error("month or day out of range");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_mode) && $stable(res_day))
    else $error("stalled result changed");

endmodule

bind date_time_setting_controller dts_checker u_dts_checker (
  .clk           (clk),
  .rst           (rst),
  .res_valid     (result.valid),
  .res_ready     (result.ready),
  .res_mode      (result.mode),
  .res_month     (result.edit_month),
  .res_day       (result.edit_day),
  .res_commit    (result.commit),
  .res_cancelled (result.cancelled)
);
